// ===== design/nau_pkg.sv =====
// nau_pkg: widths, mode codes, pipeline payload types and the sigmoid and tanh sample tables
// the tables are built at elaboration by fixed-point integer arithmetic
// no dependencies
`default_nettype none

package nau_pkg;

   localparam int DATA_WIDTH    = 16;
   localparam int TABLE_ENTRIES = 256;
   localparam int FRAC_BITS     = DATA_WIDTH - 4;
   localparam int IDX_WIDTH     = $clog2(TABLE_ENTRIES);
   localparam int POS_WIDTH     = DATA_WIDTH + IDX_WIDTH;
   localparam int PROD_WIDTH    = 2 * DATA_WIDTH + 1;
   localparam int MODE_WIDTH    = 3;

   localparam logic [MODE_WIDTH-1:0] MODE_SIGMOID  = 3'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_RELU     = 3'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_IDENTITY = 3'd2;
   localparam logic [MODE_WIDTH-1:0] MODE_BINARY   = 3'd3;
   localparam logic [MODE_WIDTH-1:0] MODE_TANH     = 3'd4;

   typedef enum logic [2:0] {
      FN_SIGMOID,
      FN_RELU,
      FN_IDENTITY,
      FN_BINARY,
      FN_TANH
   } func_type;

   localparam logic signed [DATA_WIDTH-1:0] ONE       = DATA_WIDTH'(1 << FRAC_BITS);
   localparam logic signed [DATA_WIDTH-1:0] MAX_VALUE = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [DATA_WIDTH-1:0] MIN_VALUE = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   typedef struct packed {
      func_type                       func;
      logic                           derivative;
      logic [IDX_WIDTH-1:0]           idx;
      logic [DATA_WIDTH-1:0]          frac;
      logic signed [PROD_WIDTH-1:0]   sig_prod;
      logic signed [DATA_WIDTH-1:0]   direct;
   } front_type;

   typedef struct packed {
      func_type                       func;
      logic                           derivative;
      logic signed [DATA_WIDTH-1:0]   table_value;
      logic signed [DATA_WIDTH-1:0]   simple;
   } interp_type;

   typedef logic [TABLE_ENTRIES:0][DATA_WIDTH-1:0] table_type;

   localparam logic [63:0] LN2_Q32 = 64'd2977044472;
   localparam logic [63:0] ONE_Q32 = 64'h0000_0001_0000_0000;

   // unsigned quotient by shift and subtract
   function automatic logic [63:0] udiv64(input logic [63:0] dividend,
                                          input logic [63:0] divisor);
      logic [64:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], dividend[i]};
         if (rem >= {1'b0, divisor}) begin
            rem    = rem - {1'b0, divisor};
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // exp(-t), t and result in Q32
   function automatic logic [63:0] exp_neg_q32(input logic [63:0] t);
      logic [63:0]        n;
      logic [63:0]        r;
      logic [63:0]        term;
      logic signed [63:0] sum;
      n    = udiv64(t, LN2_Q32);
      r    = t - n * LN2_Q32;
      term = ONE_Q32;
      sum  = $signed(ONE_Q32);
      for (int k = 1; k <= 24; k++) begin
         term = udiv64((term * r) >> 32, 64'(k));
         if (k[0]) begin
            sum = sum - $signed(term);
         end else begin
            sum = sum + $signed(term);
         end
      end
      if (sum < 0) begin
         sum = '0;
      end
      if (n >= 64'd63) begin
         return '0;
      end
      return $unsigned(sum) >> n;
   endfunction

   // q30 to q4.f, round half up
   function automatic logic [63:0] q30_to_fix(input logic [63:0] q);
      return (q + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
   endfunction

   function automatic table_type build_table(input logic want_tanh);
      table_type          tab;
      logic [63:0]        num;
      logic [63:0]        v_mag;
      logic [63:0]        e;
      logic [63:0]        s;
      logic [63:0]        th;
      logic signed [63:0] v;
      logic signed [63:0] fix;
      tab = '0;
      for (int k = 0; k <= TABLE_ENTRIES; k++) begin
         num   = (64'(k) * 64'd16) << 32;
         v     = $signed(udiv64(num, 64'(TABLE_ENTRIES))) - $signed(64'd8 << 32);
         v_mag = (v < 0) ? $unsigned(-v) : $unsigned(v);
         if (want_tanh) begin
            e   = exp_neg_q32(v_mag << 1);
            th  = udiv64((ONE_Q32 - e) << 30, ONE_Q32 + e);
            fix = $signed(q30_to_fix(th));
            if (v < 0) begin
               fix = -fix;
            end
         end else begin
            e = exp_neg_q32(v_mag);
            s = udiv64(64'd1 << 62, ONE_Q32 + e);
            if (v < 0) begin
               s = (64'd1 << 30) - s;
            end
            fix = $signed(q30_to_fix(s));
         end
         tab[k] = fix[DATA_WIDTH-1:0];
      end
      return tab;
   endfunction

   localparam table_type SIG_TABLE  = build_table(1'b0);
   localparam table_type TANH_TABLE = build_table(1'b1);

endpackage

`default_nettype wire

// ===== design/nau_if.sv =====
// nau_req_if and nau_rsp_if: valid/ready channels for requests and results
// depends on nau_pkg
`default_nettype none

interface nau_req_if import nau_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [DATA_WIDTH-1:0]  x_value;
   logic [MODE_WIDTH-1:0]         mode;
   logic                          derivative;

   modport source (output valid, output x_value, output mode, output derivative, input ready);
   modport sink   (input valid, input x_value, input mode, input derivative, output ready);
endinterface

interface nau_rsp_if import nau_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [DATA_WIDTH-1:0]  result_value;

   modport source (output valid, output result_value, input ready);
   modport sink   (input valid, input result_value, output ready);
endinterface

`default_nettype wire

// ===== design/nau_front.sv =====
// nau_front: first pipeline stage, mode decode, table index and fraction,
// sigmoid derivative product and the piecewise-linear functions; depends on nau_pkg
`default_nettype none

module nau_front import nau_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [DATA_WIDTH-1:0]  x_value,
   input  logic [MODE_WIDTH-1:0]         mode,
   input  logic                          derivative,
   output logic                          out_valid,
   input  logic                          out_ready,
   output front_type                     out_data
);

   logic                         valid_ff;
   logic                         valid_in;
   logic                         take;
   front_type                    data_ff;
   front_type                    data_in;
   logic [DATA_WIDTH-1:0]        offset;
   logic [POS_WIDTH-1:0]         pos;
   logic signed [DATA_WIDTH:0]   one_minus_x;

   assign take      = !valid_ff || out_ready;
   assign in_ready  = take;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      offset      = {~x_value[DATA_WIDTH-1], x_value[DATA_WIDTH-2:0]};
      pos         = POS_WIDTH'(offset) * POS_WIDTH'(TABLE_ENTRIES);
      one_minus_x = (DATA_WIDTH+1)'(ONE) - (DATA_WIDTH+1)'(x_value);

      data_in.derivative = derivative;
      data_in.idx        = pos[POS_WIDTH-1:DATA_WIDTH];
      data_in.frac       = pos[DATA_WIDTH-1:0];
      data_in.sig_prod   = PROD_WIDTH'(x_value) * PROD_WIDTH'(one_minus_x);

      unique case (mode)
         MODE_RELU:     data_in.func = FN_RELU;
         MODE_IDENTITY: data_in.func = FN_IDENTITY;
         MODE_BINARY:   data_in.func = FN_BINARY;
         MODE_TANH:     data_in.func = FN_TANH;
         default:       data_in.func = FN_SIGMOID;
      endcase

      case (data_in.func)
         FN_RELU: begin
            if (derivative) begin
               data_in.direct = (x_value > 0) ? ONE : '0;
            end else begin
               data_in.direct = (x_value > 0) ? x_value : '0;
            end
         end
         FN_IDENTITY: data_in.direct = derivative ? ONE : x_value;
         FN_BINARY: begin
            if (derivative) begin
               data_in.direct = '0;
            end else begin
               data_in.direct = (x_value >= 0) ? ONE : '0;
            end
         end
         default: data_in.direct = '0;
      endcase

      valid_in = take ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/nau_interp.sv =====
// nau_interp: three stages, table read and slope, slope times fraction, final add;
// also saturates the sigmoid derivative; depends on nau_pkg
`default_nettype none

module nau_interp import nau_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  front_type   in_data,
   output logic        out_valid,
   input  logic        out_ready,
   output interp_type  out_data
);

   typedef struct packed {
      func_type                      func;
      logic                          derivative;
      logic signed [DATA_WIDTH-1:0]  y0;
      logic [DATA_WIDTH-1:0]         dmag;
      logic                          dneg;
      logic [DATA_WIDTH-1:0]         frac;
      logic signed [DATA_WIDTH-1:0]  simple;
   } slope_type;

   typedef struct packed {
      func_type                      func;
      logic                          derivative;
      logic signed [DATA_WIDTH-1:0]  y0;
      logic [DATA_WIDTH-1:0]         mag;
      logic                          dneg;
      logic signed [DATA_WIDTH-1:0]  simple;
   } step_type;

   logic                           b_valid_ff, b_valid_in, b_take;
   logic                           c_valid_ff, c_valid_in, c_take;
   logic                           d_valid_ff, d_valid_in, d_take;
   slope_type                      b_ff, b_in;
   step_type                       c_ff, c_in;
   interp_type                     d_ff, d_in;

   logic [IDX_WIDTH:0]             idx_lo;
   logic [IDX_WIDTH:0]             idx_hi;
   logic signed [DATA_WIDTH-1:0]   y1;
   logic signed [DATA_WIDTH:0]     diff;
   logic signed [PROD_WIDTH-1:0]   shifted;
   logic [2*DATA_WIDTH:0]          scaled;

   assign d_take    = !d_valid_ff || out_ready;
   assign c_take    = !c_valid_ff || d_take;
   assign b_take    = !b_valid_ff || c_take;
   assign in_ready  = b_take;
   assign out_valid = d_valid_ff;
   assign out_data  = d_ff;

   // table read and slope
   always_comb begin
      idx_lo = {1'b0, in_data.idx};
      idx_hi = idx_lo + 1'b1;
      if (in_data.func == FN_TANH) begin
         b_in.y0 = $signed(TANH_TABLE[idx_lo]);
         y1      = $signed(TANH_TABLE[idx_hi]);
      end else begin
         b_in.y0 = $signed(SIG_TABLE[idx_lo]);
         y1      = $signed(SIG_TABLE[idx_hi]);
      end
      diff      = (DATA_WIDTH+1)'(y1) - (DATA_WIDTH+1)'(b_in.y0);
      b_in.dneg = diff[DATA_WIDTH];
      b_in.dmag = diff[DATA_WIDTH] ? DATA_WIDTH'(-diff) : DATA_WIDTH'(diff);
      b_in.frac = in_data.frac;
      b_in.func       = in_data.func;
      b_in.derivative = in_data.derivative;

      shifted = in_data.sig_prod >>> FRAC_BITS;
      if (in_data.func == FN_SIGMOID && in_data.derivative) begin
         if (shifted > PROD_WIDTH'(MAX_VALUE)) begin
            b_in.simple = MAX_VALUE;
         end else if (shifted < PROD_WIDTH'(MIN_VALUE)) begin
            b_in.simple = MIN_VALUE;
         end else begin
            b_in.simple = shifted[DATA_WIDTH-1:0];
         end
      end else begin
         b_in.simple = in_data.direct;
      end
      b_valid_in = b_take ? in_valid : b_valid_ff;
   end

   // slope times fraction, rounded half up on the magnitude
   always_comb begin
      scaled = (2*DATA_WIDTH+1)'(b_ff.dmag) * (2*DATA_WIDTH+1)'(b_ff.frac)
               + ((2*DATA_WIDTH+1)'(1) << (DATA_WIDTH - 1));
      c_in.mag        = scaled[2*DATA_WIDTH-1:DATA_WIDTH];
      c_in.y0         = b_ff.y0;
      c_in.dneg       = b_ff.dneg;
      c_in.func       = b_ff.func;
      c_in.derivative = b_ff.derivative;
      c_in.simple     = b_ff.simple;
      c_valid_in      = c_take ? b_valid_ff : c_valid_ff;
   end

   // final add
   always_comb begin
      if (c_ff.dneg) begin
         d_in.table_value = c_ff.y0 - $signed(c_ff.mag);
      end else begin
         d_in.table_value = c_ff.y0 + $signed(c_ff.mag);
      end
      d_in.func       = c_ff.func;
      d_in.derivative = c_ff.derivative;
      d_in.simple     = c_ff.simple;
      d_valid_in      = d_take ? c_valid_ff : d_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= b_valid_in;
         c_valid_ff <= c_valid_in;
         d_valid_ff <= d_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (b_take) begin
         b_ff <= b_in;
      end
      if (c_take) begin
         c_ff <= c_in;
      end
      if (d_take) begin
         d_ff <= d_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/nau_finish.sv =====
// nau_finish: last stage and output register, tanh derivative and result select
// depends on nau_pkg
`default_nettype none

module nau_finish import nau_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  interp_type                    in_data,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic signed [DATA_WIDTH-1:0]  result_value
);

   logic                            valid_ff;
   logic                            valid_in;
   logic                            take;
   logic signed [DATA_WIDTH-1:0]    result_ff;
   logic signed [DATA_WIDTH-1:0]    result_in;
   logic signed [2*DATA_WIDTH-1:0]  square;
   logic signed [DATA_WIDTH-1:0]    square_q;

   assign take         = !valid_ff || out_ready;
   assign in_ready     = take;
   assign out_valid    = valid_ff;
   assign result_value = result_ff;

   always_comb begin
      square   = (2*DATA_WIDTH)'(in_data.table_value) * (2*DATA_WIDTH)'(in_data.table_value);
      square_q = square[FRAC_BITS +: DATA_WIDTH];
      case (in_data.func)
         FN_TANH:    result_in = in_data.derivative ? (ONE - square_q) : in_data.table_value;
         FN_SIGMOID: result_in = in_data.derivative ? in_data.simple : in_data.table_value;
         default:    result_in = in_data.simple;
      endcase
      valid_in = take ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         result_ff <= result_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/neural_activation_unit.sv =====
// neural_activation_unit: sigmoid, relu, identity, binary step and tanh with derivatives
// five register stages: decode, table read, slope product, add, output register
// one request per cycle while the result side is ready; each stage holds under stall
// the sigmoid and tanh tables are constant logic, nothing to load after reset
// synchronous reset clears the stage valid bits only
// depends on nau_pkg, nau_if, nau_front, nau_interp, nau_finish
`default_nettype none

module neural_activation_unit import nau_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   nau_req_if.sink        req_chan,
   nau_rsp_if.source      rsp_chan
);

   logic        front_valid;
   logic        front_ready;
   front_type   front_data;
   logic        interp_valid;
   logic        interp_ready;
   interp_type  interp_data;

   nau_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_chan.valid),
      .in_ready   (req_chan.ready),
      .x_value    (req_chan.x_value),
      .mode       (req_chan.mode),
      .derivative (req_chan.derivative),
      .out_valid  (front_valid),
      .out_ready  (front_ready),
      .out_data   (front_data)
   );

   nau_interp u_interp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (front_data),
      .out_valid (interp_valid),
      .out_ready (interp_ready),
      .out_data  (interp_data)
   );

   nau_finish u_finish (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (interp_valid),
      .in_ready     (interp_ready),
      .in_data      (interp_data),
      .out_valid    (rsp_chan.valid),
      .out_ready    (rsp_chan.ready),
      .result_value (rsp_chan.result_value)
   );

endmodule

`default_nettype wire
